// File: rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define LFHB_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`define LFHB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define LFHB_ASSERT(lbl, clk, rst_n, cond)

`define LFHB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/lfhb_pkg.sv
`default_nettype none

package lfhb_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_FLASH  = 2'd1,
        OP_STEADY = 2'd2
    } t_op;

    localparam logic [1:0] REG_FLASH_DUR = 2'd0;
    localparam logic [1:0] REG_HB_HALF   = 2'd1;
    localparam logic [1:0] REG_MASK      = 2'd2;

    localparam logic [15:0] FLASH_DUR_RESET = 16'd50;
    localparam logic [15:0] HB_HALF_RESET   = 16'd500;
    localparam logic [31:0] MASK_RESET      = 32'd63;

    typedef struct packed {
        logic [15:0] flash_dur;
        logic [15:0] hb_half;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        on_level;
        logic [2:0]  led_index;
        logic [1:0]  op;
    } t_item;

    // wrap-safe deadline check on the signed difference
    function automatic logic reached(logic [31:0] now, logic [31:0] dl);
        logic [31:0] diff;
        begin
            diff = now - dl;
            return ~diff[31];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/lfhb_apb_regs.sv
`default_nettype none

module lfhb_apb_regs #(
    parameter int NUM_LEDS = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output lfhb_pkg::t_cfg           o_cfg,
    output logic      [NUM_LEDS-1:0] o_mask
);

    lfhb_pkg::t_cfg      r_cfg;
    logic [NUM_LEDS-1:0] r_mask;
    logic                wr_en;

    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flash_dur <= lfhb_pkg::FLASH_DUR_RESET;
            r_cfg.hb_half   <= lfhb_pkg::HB_HALF_RESET;
            r_mask          <= NUM_LEDS'(lfhb_pkg::MASK_RESET);
        end else if (wr_en) begin
            case (paddr[3:2])
                lfhb_pkg::REG_FLASH_DUR: r_cfg.flash_dur <= pwdata[15:0];
                lfhb_pkg::REG_HB_HALF:   r_cfg.hb_half   <= pwdata[15:0];
                lfhb_pkg::REG_MASK:      r_mask          <= pwdata[NUM_LEDS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lfhb_pkg::REG_FLASH_DUR: prdata = {16'd0, r_cfg.flash_dur};
            lfhb_pkg::REG_HB_HALF:   prdata = {16'd0, r_cfg.hb_half};
            lfhb_pkg::REG_MASK:      prdata = 32'(r_mask);
            default:                 prdata = 32'd0;
        endcase
    end

    assign o_cfg  = r_cfg;
    assign o_mask = r_mask;

endmodule

`default_nettype wire

// File: rtl/lfhb_core.sv
`default_nettype none

module lfhb_core #(
    parameter int NUM_LEDS = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lfhb_pkg::t_cfg      i_cfg,
    input  wire logic [NUM_LEDS-1:0] i_mask,
    input  wire logic                i_in_vld,
    output logic                     o_in_rdy,
    input  wire lfhb_pkg::t_item     i_item,
    output logic                     o_out_vld,
    input  wire logic                i_out_rdy,
    output logic      [NUM_LEDS-1:0] o_levels
);

    localparam int HB = NUM_LEDS - 1;

    logic                r_in_vld;
    lfhb_pkg::t_item     r_item;
    logic                r_out_vld;
    logic [NUM_LEDS-1:0] r_out;

    logic [NUM_LEDS-1:0] r_steady, n_steady;
    logic [NUM_LEDS-1:0] r_flashing, n_flashing;
    logic [NUM_LEDS-1:0] r_driven, n_driven;
    logic [31:0]         r_deadline [NUM_LEDS];
    logic [31:0]         n_deadline [NUM_LEDS];
    logic [31:0]         r_hb_next, n_hb_next;
    logic                r_hb_level, n_hb_level;

    logic                advance;
    logic [NUM_LEDS-1:0] sel;
    logic [31:0]         flash_end;
    logic [31:0]         hb_end;

    assign advance   = !r_out_vld || i_out_rdy;
    assign o_in_rdy  = !r_in_vld || advance;
    assign flash_end = r_item.now_ms + {16'd0, i_cfg.flash_dur};
    assign hb_end    = r_item.now_ms + {16'd0, i_cfg.hb_half};

    always_comb begin
        for (int k = 0; k < NUM_LEDS; k++) begin
            sel[k] = (32'(r_item.led_index) == k);
        end
    end

    always_comb begin
        n_steady   = r_steady;
        n_flashing = r_flashing;
        n_driven   = r_driven;
        n_hb_next  = r_hb_next;
        n_hb_level = r_hb_level;
        for (int k = 0; k < NUM_LEDS; k++) begin
            n_deadline[k] = r_deadline[k];
        end
        case (lfhb_pkg::t_op'(r_item.op))
            lfhb_pkg::OP_FLASH: begin
                for (int k = 0; k < NUM_LEDS; k++) begin
                    if (sel[k] && i_mask[k]) begin
                        n_flashing[k] = 1'b1;
                        n_deadline[k] = flash_end;
                        n_driven[k]   = 1'b1;
                    end
                end
            end
            lfhb_pkg::OP_STEADY: begin
                for (int k = 0; k < NUM_LEDS; k++) begin
                    if (sel[k]) begin
                        n_steady[k] = r_item.on_level;
                        if (!r_flashing[k] && i_mask[k]) begin
                            n_driven[k] = r_item.on_level;
                        end
                    end
                end
            end
            lfhb_pkg::OP_TICK: begin
                for (int k = 0; k < NUM_LEDS; k++) begin
                    if (r_flashing[k] && lfhb_pkg::reached(r_item.now_ms, r_deadline[k])) begin
                        n_flashing[k] = 1'b0;
                        if (i_mask[k]) begin
                            n_driven[k] = r_steady[k];
                        end
                    end
                end
                if (i_mask[HB] && !n_flashing[HB]) begin
                    if (r_hb_next == 32'd0) begin
                        n_hb_next = hb_end;
                    end else if (lfhb_pkg::reached(r_item.now_ms, r_hb_next)) begin
                        n_hb_level   = !r_hb_level;
                        n_driven[HB] = !r_hb_level;
                        n_hb_next    = hb_end;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_steady   <= '0;
            r_flashing <= '0;
            r_driven   <= '0;
            r_hb_next  <= 32'd0;
            r_hb_level <= 1'b0;
            for (int k = 0; k < NUM_LEDS; k++) begin
                r_deadline[k] <= 32'd0;
            end
        end else begin
            if (o_in_rdy) begin
                r_in_vld <= i_in_vld;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (advance && r_in_vld) begin
                r_steady   <= n_steady;
                r_flashing <= n_flashing;
                r_driven   <= n_driven;
                r_hb_next  <= n_hb_next;
                r_hb_level <= n_hb_level;
                for (int k = 0; k < NUM_LEDS; k++) begin
                    r_deadline[k] <= n_deadline[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_rdy && i_in_vld) begin
            r_item <= i_item;
        end
        if (advance && r_in_vld) begin
            r_out <= n_driven & i_mask;
        end
    end

    assign o_out_vld = r_out_vld;
    assign o_levels  = r_out;

endmodule

`default_nettype wire

// File: rtl/led_flash_heartbeat_driver_top.sv
// an accepted input beat is registered into r_item, and its result beat is registered into r_out
// throughput: one beat per cycle while m_tready does not stall the output, the state update is a single registered pass
// per-led deadline compares and one heartbeat compare run in parallel
// reset: synchronous active low, clears the led steady, flash, deadline and heartbeat state and loads register defaults
`default_nettype none

`include "assert_macros.svh"

module led_flash_heartbeat_driver_top #(
    parameter  int NUM_LEDS = 6,
    localparam int OUT_W    = ((NUM_LEDS + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // op[1:0], led_index[4:2], on_level[5], now_ms[37:6], zero pad
    input  wire logic [39:0]          s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // led_levels from bit 0, zero pad
    output logic      [OUT_W-1:0]     m_tdata,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [3:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready
);

    lfhb_pkg::t_cfg      w_cfg;
    logic [NUM_LEDS-1:0] w_mask;
    logic [NUM_LEDS-1:0] w_levels;
    lfhb_pkg::t_item     w_item;

    assign w_item = lfhb_pkg::t_item'(s_tdata[37:0]);

    lfhb_apb_regs #(
        .NUM_LEDS (NUM_LEDS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_mask  (w_mask)
    );

    lfhb_core #(
        .NUM_LEDS (NUM_LEDS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_mask    (w_mask),
        .i_in_vld  (s_tvalid),
        .o_in_rdy  (s_tready),
        .i_item    (w_item),
        .o_out_vld (m_tvalid),
        .i_out_rdy (m_tready),
        .o_levels  (w_levels)
    );

    assign m_tdata = OUT_W'(w_levels);

    `LFHB_ASSERT_IMPL(a_absent_low, i_clk, i_rst_n, m_tvalid, (w_levels & ~w_mask) == '0)
    `LFHB_ASSERT_IMPL(a_ready_when_empty, i_clk, i_rst_n, !m_tvalid, s_tready)

endmodule

`default_nettype wire
